// File: src/assert_macros.svh
// shared assertion helpers, clocked on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/istbl_pkg.sv
package istbl_pkg;

  localparam int unsigned MaxRangesDef = 64;
  localparam int unsigned CodeW = 32;
  localparam int unsigned CountW = 33;
  localparam int unsigned UsedW = 7;
  localparam int unsigned InDataW = 104;
  localparam int unsigned OutDataW = 48;

  localparam logic [2:0] ReqAdd = 3'd0;
  localparam logic [2:0] ReqSub = 3'd1;
  localparam logic [2:0] ReqQuery = 3'd2;
  localparam logic [2:0] ReqClear = 3'd3;
  localparam logic [2:0] ReqCount = 3'd4;

  typedef enum logic [1:0] {
    OP_INS,
    OP_REM,
    OP_QRY,
    OP_CNT
  } op_e;

  typedef struct packed {
    logic              w0_v;
    logic [CodeW-1:0]  w0_s;
    logic [CodeW-1:0]  w0_e;
    logic              w1_v;
    logic [CodeW-1:0]  w1_s;
    logic [CodeW-1:0]  w1_e;
    logic [CodeW-1:0]  nlo;
    logic [CodeW-1:0]  nhi;
    logic              placed;
    logic              hit;
    logic [CountW-1:0] span;
  } eval_t;

endpackage

// File: src/interval_set_range_table_core.sv
// one request at a time; the next input transfer waits until the result is taken
// add/subtract: per stored range ST_RD, ST_EV and, for a second entry, ST_W2; then ST_FIN
// query inside the bounds and count: per stored range ST_RD and ST_EV; then ST_FIN
// clear, out-of-bounds query and unknown requests: straight to ST_FIN, no table read
// asynchronous active-low reset empties the table and clears invert mode; no clearing pass
// table is double-buffered: a rebuild goes to the idle bank and is kept only if it fits
`include "assert_macros.svh"

module interval_set_range_table_core #(
  parameter int unsigned MaxRanges = istbl_pkg::MaxRangesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i,     // invert_mode
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // req_type[2:0], range_lo[34:3], range_hi[66:35], query_char[98:67], zero pad
  input  logic [istbl_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // is_member[0], member_count[33:1], table_full[34], ranges_used[41:35], zero pad
  output logic [istbl_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned IdxW = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;
  localparam int unsigned CntW = $clog2(MaxRanges + 1);
  localparam int unsigned AddrW = IdxW + 1;
  localparam int unsigned CW = istbl_pkg::CodeW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_W2,
    ST_FIN
  } state_e;

  state_e                      state_q;
  istbl_pkg::op_e              op_q;
  logic [2:0]                  req_q;
  logic [CW-1:0]               lo_q, hi_q, qc_q, nlo_q, nhi_q, w1s_q, w1e_q;
  logic [CW-1:0]               lowest_q, highest_q;
  logic                        placed_q, ovf_q, hit_q, bank_q, inv_q;
  logic [CntW-1:0]             k_q, n_q, total_q;
  logic [istbl_pkg::CountW-1:0] sum_q;
  logic [istbl_pkg::OutDataW-1:0] out_q;
  logic                        out_v_q;

  logic [2:0]                  in_req;
  logic [CW-1:0]               in_a, in_b, in_lo, in_hi, in_q;
  logic [2*CW-1:0]             rdata;
  istbl_pkg::eval_t            ev;
  logic                        wr_req, we, n_full, last_k, ovf_fin;
  logic [CW-1:0]               wr_s, wr_e;
  logic [CntW-1:0]             n_fin;

  assign in_req = s_axis_tdata[2:0];
  assign in_a = s_axis_tdata[34:3];
  assign in_b = s_axis_tdata[66:35];
  assign in_q = s_axis_tdata[98:67];
  assign in_lo = (in_a > in_b) ? in_b : in_a;
  assign in_hi = (in_a > in_b) ? in_a : in_b;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  istbl_ram #(
    .AddrW(AddrW),
    .DataW(2 * CW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i({~bank_q, n_q[IdxW-1:0]}),
    .wdata_i({wr_s, wr_e}),
    .raddr_i({bank_q, k_q[IdxW-1:0]}),
    .rdata_o(rdata)
  );

  istbl_eval u_eval (
    .op_i    (op_q),
    .s_i     (rdata[2*CW-1:CW]),
    .e_i     (rdata[CW-1:0]),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .nlo_i   (nlo_q),
    .nhi_i   (nhi_q),
    .placed_i(placed_q),
    .q_i     (qc_q),
    .res_o   (ev)
  );

  always_comb begin
    wr_req = 1'b0;
    wr_s = ev.w0_s;
    wr_e = ev.w0_e;
    unique case (state_q)
      ST_EV: wr_req = ev.w0_v;
      ST_W2: begin
        wr_req = 1'b1;
        wr_s = w1s_q;
        wr_e = w1e_q;
      end
      ST_FIN: begin
        wr_req = (op_q == istbl_pkg::OP_INS) && !placed_q;
        wr_s = nlo_q;
        wr_e = nhi_q;
      end
      default: ;
    endcase
  end

  assign n_full = (n_q == CntW'(MaxRanges));
  assign we = wr_req && !n_full;
  assign last_k = (k_q + CntW'(1)) >= total_q;
  assign ovf_fin = ovf_q || (wr_req && n_full);
  assign n_fin = we ? n_q + CntW'(1) : n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q <= istbl_pkg::OP_QRY;
      req_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      qc_q <= '0;
      nlo_q <= '0;
      nhi_q <= '0;
      w1s_q <= '0;
      w1e_q <= '0;
      lowest_q <= '1;
      highest_q <= '0;
      placed_q <= 1'b0;
      ovf_q <= 1'b0;
      hit_q <= 1'b0;
      bank_q <= 1'b0;
      inv_q <= 1'b0;
      k_q <= '0;
      n_q <= '0;
      total_q <= '0;
      sum_q <= '0;
      out_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        inv_q <= cfg_data_i;
      end
      if (out_v_q && m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      if (wr_req) begin
        if (n_full) ovf_q <= 1'b1;
        else n_q <= n_q + CntW'(1);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            req_q <= in_req;
            lo_q <= in_lo;
            hi_q <= in_hi;
            qc_q <= in_q;
            nlo_q <= in_lo;
            nhi_q <= in_hi;
            placed_q <= 1'b0;
            ovf_q <= 1'b0;
            hit_q <= 1'b0;
            sum_q <= '0;
            k_q <= '0;
            n_q <= '0;
            state_q <= ST_FIN;
            unique case (in_req)
              istbl_pkg::ReqAdd, istbl_pkg::ReqSub: begin
                op_q <= ((in_req == istbl_pkg::ReqAdd) ^ inv_q) ? istbl_pkg::OP_INS
                                                               : istbl_pkg::OP_REM;
                if (total_q != '0) state_q <= ST_RD;
              end
              istbl_pkg::ReqQuery: begin
                op_q <= istbl_pkg::OP_QRY;
                // bounds only widen until a clear, so outside them nothing can match
                if (total_q != '0 && in_q >= lowest_q && in_q <= highest_q) begin
                  state_q <= ST_RD;
                end
              end
              istbl_pkg::ReqCount: begin
                op_q <= istbl_pkg::OP_CNT;
                if (total_q != '0) state_q <= ST_RD;
              end
              istbl_pkg::ReqClear: begin
                op_q <= istbl_pkg::OP_CNT;
                total_q <= '0;
                lowest_q <= '1;
                highest_q <= '0;
              end
              default: op_q <= istbl_pkg::OP_CNT;
            endcase
          end
        end
        ST_RD: state_q <= ST_EV;
        ST_EV: begin
          nlo_q <= ev.nlo;
          nhi_q <= ev.nhi;
          placed_q <= ev.placed;
          hit_q <= hit_q | ev.hit;
          sum_q <= sum_q + ev.span;
          w1s_q <= ev.w1_s;
          w1e_q <= ev.w1_e;
          if (ev.w1_v) begin
            state_q <= ST_W2;
          end else if (last_k) begin
            state_q <= ST_FIN;
          end else begin
            k_q <= k_q + CntW'(1);
            state_q <= ST_RD;
          end
        end
        ST_W2: begin
          if (last_k) begin
            state_q <= ST_FIN;
          end else begin
            k_q <= k_q + CntW'(1);
            state_q <= ST_RD;
          end
        end
        ST_FIN: begin
          logic tbl_op;
          logic full;
          logic mem_bit;
          logic [istbl_pkg::CountW-1:0] cnt_val;
          logic [istbl_pkg::UsedW-1:0] used_val;
          tbl_op = (req_q == istbl_pkg::ReqAdd) || (req_q == istbl_pkg::ReqSub);
          full = tbl_op && ovf_fin;
          mem_bit = (req_q == istbl_pkg::ReqQuery) ? (hit_q ^ inv_q) : 1'b0;
          cnt_val = (req_q == istbl_pkg::ReqCount) ? sum_q : '0;
          used_val = istbl_pkg::UsedW'((tbl_op && !ovf_fin) ? n_fin : total_q);
          if (tbl_op && !ovf_fin) begin
            bank_q <= ~bank_q;
            total_q <= n_fin;
            if (op_q == istbl_pkg::OP_INS) begin
              if (lo_q < lowest_q) lowest_q <= lo_q;
              if (hi_q > highest_q) highest_q <= hi_q;
            end
          end
          out_q <= istbl_pkg::OutDataW'({used_val, full, cnt_val, mem_bit});
          out_v_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_total_cap, total_q <= CntW'(MaxRanges), "range count above capacity")
  `ASSERT_IMPL(a_wr_in_range, we, n_q < CntW'(MaxRanges), "table write past capacity")
  `ASSERT_IMPL(a_busy_not_ready, state_q != ST_IDLE, !s_axis_tready, "ready while busy")
  `ASSERT_NEXT(a_bank_commit, state_q != ST_FIN, $stable(bank_q), "bank swap outside commit")

endmodule

// File: src/istbl_ram.sv
module istbl_ram #(
  parameter int unsigned AddrW = 7,
  parameter int unsigned DataW = 64
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [1 << AddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/istbl_eval.sv
module istbl_eval (
  input  istbl_pkg::op_e                   op_i,
  input  logic [istbl_pkg::CodeW-1:0]      s_i,
  input  logic [istbl_pkg::CodeW-1:0]      e_i,
  input  logic [istbl_pkg::CodeW-1:0]      lo_i,
  input  logic [istbl_pkg::CodeW-1:0]      hi_i,
  input  logic [istbl_pkg::CodeW-1:0]      nlo_i,
  input  logic [istbl_pkg::CodeW-1:0]      nhi_i,
  input  logic                             placed_i,
  input  logic [istbl_pkg::CodeW-1:0]      q_i,
  output istbl_pkg::eval_t                 res_o
);

  always_comb begin
    res_o = '0;
    res_o.nlo = nlo_i;
    res_o.nhi = nhi_i;
    res_o.placed = placed_i;
    unique case (op_i)
      istbl_pkg::OP_INS: begin
        if (e_i < lo_i && (lo_i - e_i) > 32'd1) begin
          res_o.w0_v = 1'b1;
          res_o.w0_s = s_i;
          res_o.w0_e = e_i;
        end else if (s_i > hi_i && (s_i - hi_i) > 32'd1) begin
          res_o.w0_v = 1'b1;
          if (!placed_i) begin
            // new range goes in ahead of the first entry past it
            res_o.w0_s = nlo_i;
            res_o.w0_e = nhi_i;
            res_o.w1_v = 1'b1;
            res_o.w1_s = s_i;
            res_o.w1_e = e_i;
            res_o.placed = 1'b1;
          end else begin
            res_o.w0_s = s_i;
            res_o.w0_e = e_i;
          end
        end else begin
          if (s_i < nlo_i) res_o.nlo = s_i;
          if (e_i > nhi_i) res_o.nhi = e_i;
        end
      end
      istbl_pkg::OP_REM: begin
        if (e_i < lo_i || s_i > hi_i) begin
          res_o.w0_v = 1'b1;
          res_o.w0_s = s_i;
          res_o.w0_e = e_i;
        end else begin
          if (s_i < lo_i) begin
            res_o.w0_v = 1'b1;
            res_o.w0_s = s_i;
            res_o.w0_e = lo_i - 32'd1;
          end
          if (e_i > hi_i) begin
            if (s_i < lo_i) begin
              res_o.w1_v = 1'b1;
              res_o.w1_s = hi_i + 32'd1;
              res_o.w1_e = e_i;
            end else begin
              res_o.w0_v = 1'b1;
              res_o.w0_s = hi_i + 32'd1;
              res_o.w0_e = e_i;
            end
          end
        end
      end
      istbl_pkg::OP_QRY: begin
        res_o.hit = (s_i <= q_i) && (q_i <= e_i);
      end
      istbl_pkg::OP_CNT: begin
        res_o.span = {1'b0, e_i - s_i} + 33'd1;
      end
      default: ;
    endcase
  end

endmodule

// File: tb/sv/interval_set_range_table_core_tb.sv
`timescale 1ns / 100ps

module interval_set_range_table_core_tb;

  localparam int unsigned Depth = istbl_pkg::MaxRangesDef;
  localparam int unsigned CodeW = istbl_pkg::CodeW;
  localparam int unsigned CountW = istbl_pkg::CountW;
  localparam int unsigned UsedW = istbl_pkg::UsedW;
  localparam logic [2:0] ReqUnknownLo = 3'd5;
  localparam logic [2:0] ReqUnknownHi = 3'd7;
  localparam logic [CodeW-1:0] CodeMax = '1;
  localparam int unsigned CycleLimit = 2_000_000;

  typedef struct {
    logic              member;
    logic [CountW-1:0] count;
    logic              full;
    logic [UsedW-1:0]  used;
  } table_result_t;

  // software copy of the range table plus the queue of outcomes it predicts
  class range_table_sb;
    logic [CodeW-1:0] starts[Depth];
    logic [CodeW-1:0] ends[Depth];
    logic [CodeW-1:0] work_s[Depth+1];
    logic [CodeW-1:0] work_e[Depth+1];
    int unsigned      total;
    logic [CodeW-1:0] low_bound;
    logic [CodeW-1:0] high_bound;
    logic             invert;
    table_result_t    outcomes[$];
    int               errors;

    function void reset_state();
      total = 0;
      low_bound = CodeMax;
      high_bound = '0;
      invert = 1'b0;
      errors = 0;
    endfunction

    function bit commit(int unsigned n);
      if (n > Depth) return 1'b1;
      for (int k = 0; k < n; k++) begin
        starts[k] = work_s[k];
        ends[k] = work_e[k];
      end
      total = n;
      return 1'b0;
    endfunction

    function bit merge_in(logic [CodeW-1:0] lo, logic [CodeW-1:0] hi);
      int unsigned n;
      logic [CodeW-1:0] nlo, nhi, s, e;
      bit placed;
      n = 0;
      nlo = lo;
      nhi = hi;
      placed = 0;
      for (int k = 0; k < total; k++) begin
        s = starts[k];
        e = ends[k];
        if (e < lo && (lo - e) > 1) begin
          work_s[n] = s; work_e[n] = e; n++;
        end else if (s > hi && (s - hi) > 1) begin
          if (!placed) begin
            work_s[n] = nlo; work_e[n] = nhi; n++;
            placed = 1;
          end
          work_s[n] = s; work_e[n] = e; n++;
        end else begin
          if (s < nlo) nlo = s;
          if (e > nhi) nhi = e;
        end
      end
      if (!placed) begin
        work_s[n] = nlo; work_e[n] = nhi; n++;
      end
      if (commit(n)) return 1'b1;
      if (lo < low_bound) low_bound = lo;
      if (hi > high_bound) high_bound = hi;
      return 1'b0;
    endfunction

    function bit cut_out(logic [CodeW-1:0] lo, logic [CodeW-1:0] hi);
      int unsigned n;
      logic [CodeW-1:0] s, e;
      n = 0;
      for (int k = 0; k < total; k++) begin
        s = starts[k];
        e = ends[k];
        if (e < lo || s > hi) begin
          work_s[n] = s; work_e[n] = e; n++;
        end else begin
          if (s < lo) begin
            work_s[n] = s; work_e[n] = lo - 1; n++;
          end
          if (e > hi) begin
            work_s[n] = hi + 1; work_e[n] = e; n++;
          end
        end
      end
      return commit(n);
    endfunction

    function void note_request(logic [2:0] req, logic [CodeW-1:0] a, logic [CodeW-1:0] b,
                               logic [CodeW-1:0] code);
      table_result_t r;
      logic [CodeW-1:0] lo, hi;
      lo = (a > b) ? b : a;
      hi = (a > b) ? a : b;
      r.member = 0;
      r.count = '0;
      r.full = 0;
      case (req)
        istbl_pkg::ReqAdd:   r.full = invert ? cut_out(lo, hi) : merge_in(lo, hi);
        istbl_pkg::ReqSub:   r.full = invert ? merge_in(lo, hi) : cut_out(lo, hi);
        istbl_pkg::ReqQuery: begin
          if (code >= low_bound && code <= high_bound)
            for (int k = 0; k < total; k++)
              if (starts[k] <= code && code <= ends[k]) r.member = 1;
          r.member ^= invert;
        end
        istbl_pkg::ReqClear: begin
          total = 0;
          low_bound = CodeMax;
          high_bound = '0;
        end
        istbl_pkg::ReqCount: begin
          for (int k = 0; k < total; k++)
            r.count += CountW'(ends[k] - starts[k]) + 1;
        end
        default: ;
      endcase
      r.used = UsedW'(total);
      outcomes.push_back(r);
    endfunction

    function void check_result(logic [istbl_pkg::OutDataW-1:0] d);
      table_result_t x, got;
      got.member = d[0];
      got.count = d[33:1];
      got.full = d[34];
      got.used = d[41:35];
      if (outcomes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      x = outcomes.pop_front();
      if (got.member !== x.member) begin
        $display("%0t: is_member exp %0d got %0d", $time, x.member, got.member);
        errors++;
      end
      if (got.count !== x.count) begin
        $display("%0t: member_count exp %0d got %0d", $time, x.count, got.count);
        errors++;
      end
      if (got.full !== x.full) begin
        $display("%0t: table_full exp %0d got %0d", $time, x.full, got.full);
        errors++;
      end
      if (got.used !== x.used) begin
        $display("%0t: ranges_used exp %0d got %0d", $time, x.used, got.used);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [istbl_pkg::InDataW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [istbl_pkg::OutDataW-1:0] m_axis_tdata;

  range_table_sb sb;
  int unsigned sent_count;
  int unsigned cycle_count;
  logic [CodeW-1:0] window_base;

  interval_set_range_table_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // receiver: changing stall pattern, with one long hold-off to back up the input
  initial begin
    int unsigned hold_left, tick, mode;
    bit hold_done;
    hold_left = 0;
    tick = 0;
    mode = 0;
    hold_done = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (tick % 300 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (!hold_done && sent_count >= 400) begin
        hold_done = 1;
        hold_left = 3000;
        m_axis_tready = 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = ($urandom_range(0, 1) == 0);
          2: m_axis_tready = (tick % 4 == 0);
          default: m_axis_tready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // offers one request and holds it until the transfer; valid stays high afterwards
  task automatic send_req(logic [2:0] req, logic [CodeW-1:0] a, logic [CodeW-1:0] b,
                          logic [CodeW-1:0] code);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {5'd0, code, b, a, req};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(req, a, b, code);
    sent_count++;
  endtask

  task automatic pause_sender(int unsigned cycles);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic write_invert(logic value);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.outcomes.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.invert = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [CodeW-1:0] pick_code();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return CodeMax - $urandom_range(0, 40);
      2: return $urandom_range(0, 40);
      default: return window_base + $urandom_range(0, 400);
    endcase
  endfunction

  task automatic random_request();
    logic [CodeW-1:0] a, b;
    int unsigned pick;
    a = pick_code();
    b = ($urandom_range(0, 4) == 0) ? pick_code() : a + $urandom_range(0, 6);
    pick = $urandom_range(0, 99);
    if (pick < 38) send_req(istbl_pkg::ReqAdd, a, b, pick_code());
    else if (pick < 58) send_req(istbl_pkg::ReqSub, a, b, pick_code());
    else if (pick < 85) send_req(istbl_pkg::ReqQuery, a, b, pick_code());
    else if (pick < 93) send_req(istbl_pkg::ReqCount, a, b, pick_code());
    else if (pick < 96) send_req(istbl_pkg::ReqClear, a, b, pick_code());
    else send_req(3'($urandom_range(ReqUnknownLo, ReqUnknownHi)), a, b, pick_code());
  endtask

  // spaced single codes so the table runs past its capacity
  task automatic fill_table();
    logic [CodeW-1:0] base;
    base = window_base;
    for (int k = 0; k < Depth + 4; k++) begin
      send_req(istbl_pkg::ReqAdd, base + 3 * k, base + 3 * k, base);
    end
    send_req(istbl_pkg::ReqSub, base + 1, base + 1, base);
    send_req(istbl_pkg::ReqSub, base + 4, base + 6, base);
    send_req(istbl_pkg::ReqCount, '0, '0, '0);
  endtask

  initial begin
    int unsigned burst;
    sb = new();
    sb.reset_state();
    sent_count = 0;
    window_base = 32'h1000;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_invert(1'b0);

    send_req(istbl_pkg::ReqAdd, 32'd0, 32'd0, 32'd0);
    send_req(istbl_pkg::ReqAdd, CodeMax, CodeMax - 1, 32'd0);
    send_req(istbl_pkg::ReqQuery, 32'd0, 32'd0, 32'd0);
    send_req(istbl_pkg::ReqQuery, 32'd0, 32'd0, CodeMax);
    send_req(istbl_pkg::ReqQuery, 32'd0, 32'd0, 32'd1);
    send_req(istbl_pkg::ReqAdd, 32'd5, 32'd2, 32'd0);
    send_req(istbl_pkg::ReqAdd, 32'd1, 32'd1, 32'd0);
    send_req(istbl_pkg::ReqSub, 32'd3, 32'd3, 32'd0);
    send_req(istbl_pkg::ReqQuery, 32'd0, 32'd0, 32'd3);
    send_req(istbl_pkg::ReqQuery, 32'd0, 32'd0, 32'd4);
    send_req(istbl_pkg::ReqCount, 32'd0, 32'd0, 32'd0);
    send_req(istbl_pkg::ReqSub, CodeMax, 32'd0, 32'd0);
    send_req(istbl_pkg::ReqCount, 32'd0, 32'd0, 32'd0);
    send_req(istbl_pkg::ReqAdd, 32'd0, CodeMax, 32'd0);
    send_req(istbl_pkg::ReqCount, 32'd0, 32'd0, 32'd0);
    send_req(istbl_pkg::ReqQuery, 32'd0, 32'd0, 32'h8000_0000);
    send_req(istbl_pkg::ReqClear, CodeMax, CodeMax, CodeMax);
    send_req(istbl_pkg::ReqQuery, 32'd0, 32'd0, 32'd0);
    for (int u = ReqUnknownLo; u <= ReqUnknownHi; u++) begin
      send_req(3'(u), $urandom, $urandom, $urandom);
    end
    send_req(istbl_pkg::ReqCount, 32'd0, 32'd0, 32'd0);

    for (int phase = 0; phase < 5; phase++) begin
      write_invert(phase[0]);
      window_base = $urandom;
      burst = 0;
      for (int i = 0; i < 180; i++) begin
        if (i == 90) fill_table();
        else random_request();
        if (burst == 0) begin
          burst = $urandom_range(1, 25);
          if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 6));
        end else begin
          burst--;
        end
      end
      send_req(istbl_pkg::ReqClear, 32'd0, 32'd0, 32'd0);
    end
    write_invert(1'b1);
    send_req(istbl_pkg::ReqCount, 32'd0, 32'd0, 32'd0);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.outcomes.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (sb.errors == 0 && sb.outcomes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
